// File: sv/rgbbmp_pkg.sv
// shared types, constants and byte formatting for the rgb565 to bmp24 stream core
`timescale 1ns / 1ps

package rgbbmp_pkg;

    localparam int WIDTH_W   = 9;
    localparam int HEIGHT_W  = 10;
    localparam int COORD_W   = 10;
    localparam int PIXEL_W   = 16;
    localparam int ROWB_W    = 11;
    localparam int IMG_W     = 21;
    localparam int IDX_W     = 6;
    localparam int OP_W      = 2;
    localparam int CFG_W     = 10;
    localparam int S_DATA_W  = 56;

    localparam int MAX_WIDTH_DEF = 480;
    localparam int MAX_WIDTH_W   = 13;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 9'd480;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 10'd320;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_TILE  = 2'd1;
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [IDX_W-1:0] HDR_LAST_IDX = 6'd53;
    localparam logic [31:0] HDR_BYTES     = 32'd54;
    localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
    localparam logic [31:0] BITS_PER_PIX  = 32'd24;
    localparam logic [31:0] PLANES        = 32'd1;
    localparam logic [7:0]  MAGIC_B       = 8'h42;
    localparam logic [7:0]  MAGIC_M       = 8'h4D;

    // one run of output bytes handed from the control stage to the emitter
    typedef struct packed {
        logic                is_hdr;
        logic [IDX_W-1:0]    last_idx;
        logic                failed;
        logic [WIDTH_W-1:0]  hdr_width;
        logic [HEIGHT_W-1:0] hdr_height;
        logic [IMG_W-1:0]    hdr_img;
        logic [23:0]         pix_bgr;
    } job_t;

    function automatic logic [7:0] le_byte(input logic [31:0] word, input logic [1:0] sel);
        logic [31:0] sh;
        sh = word >> {sel, 3'b000};
        return sh[7:0];
    endfunction

    function automatic logic [7:0] header_byte(
        input logic [IDX_W-1:0]    idx,
        input logic [WIDTH_W-1:0]  width,
        input logic [HEIGHT_W-1:0] height,
        input logic [IMG_W-1:0]    img
    );
        logic [31:0]      img32;
        logic [31:0]      fsize;
        logic [31:0]      neg_h;
        logic [IDX_W-1:0] rel;
        logic [1:0]       sel;
        logic [7:0]       b;
        img32 = {{(32-IMG_W){1'b0}}, img};
        fsize = img32 + HDR_BYTES;
        neg_h = 32'd0 - {{(32-HEIGHT_W){1'b0}}, height};
        rel   = idx - 6'd2;
        // multi-byte fields start at an offset of 2 mod 4, except bits per pixel
        sel   = rel[1:0];
        case (idx) inside
            6'd0:       b = MAGIC_B;
            6'd1:       b = MAGIC_M;
            [6'd2:6'd5]:   b = le_byte(fsize, sel);
            [6'd10:6'd13]: b = le_byte(HDR_BYTES, sel);
            [6'd14:6'd17]: b = le_byte(INFO_HDR_SIZE, sel);
            [6'd18:6'd21]: b = le_byte({{(32-WIDTH_W){1'b0}}, width}, sel);
            [6'd22:6'd25]: b = le_byte(neg_h, sel);
            [6'd26:6'd27]: b = le_byte(PLANES, sel);
            [6'd28:6'd29]: b = le_byte(BITS_PER_PIX, {1'b0, idx[0]});
            [6'd34:6'd37]: b = le_byte(img32, sel);
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/rgbbmp_ctrl.sv
// input register, image and tile state, and formation of byte runs
`timescale 1ns / 1ps

module rgbbmp_ctrl #(
    parameter int MAX_WIDTH = rgbbmp_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rgbbmp_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [rgbbmp_pkg::OP_W-1:0]        s_tuser,
    input  logic [rgbbmp_pkg::WIDTH_W-1:0]     image_width,
    input  logic [rgbbmp_pkg::HEIGHT_W-1:0]    image_height,
    input  logic                               job_ready,
    output logic                               job_load,
    output rgbbmp_pkg::job_t                   job
);

    localparam int CW = rgbbmp_pkg::COORD_W;
    localparam int WW = rgbbmp_pkg::WIDTH_W;
    localparam int HW = rgbbmp_pkg::HEIGHT_W;

    logic                            in_valid_reg;
    logic [rgbbmp_pkg::OP_W-1:0]     op_reg;
    logic [CW-1:0]                   col_first_reg;
    logic [CW-1:0]                   col_last_reg;
    logic [CW-1:0]                   row_first_reg;
    logic [CW-1:0]                   row_last_reg;
    logic [rgbbmp_pkg::PIXEL_W-1:0]  pixel_reg;

    logic          open_reg, open_next;
    logic          fail_reg, fail_next;
    logic [HW-1:0] row_reg, row_next;
    logic [WW-1:0] col_reg, col_next;
    logic [CW-1:0] tile_end_reg, tile_end_next;
    logic          tile_act_reg, tile_act_next;

    logic                          in_take;
    logic                          needs_job;
    logic                          tile_bad;
    logic                          pix_emit;
    logic [WW-1:0]                 col_inc;
    logic                          row_done;
    logic [rgbbmp_pkg::ROWB_W-1:0] sum3;
    logic [rgbbmp_pkg::ROWB_W-1:0] stride_bytes;
    logic [1:0]                    pad;
    logic [4:0]                    blue5;
    logic [5:0]                    green6;
    logic [4:0]                    red5;

    assign in_take  = in_valid_reg && (!needs_job || job_ready);
    assign s_tready = !in_valid_reg || in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg        <= s_tuser;
            col_first_reg <= s_tdata[9:0];
            col_last_reg  <= s_tdata[19:10];
            row_first_reg <= s_tdata[29:20];
            row_last_reg  <= s_tdata[39:30];
            pixel_reg     <= s_tdata[55:40];
        end
    end

    // 3*w+3 rounded down to a multiple of four gives the padded row length
    assign sum3         = 11'(image_width) * 11'd3 + 11'd3;
    assign stride_bytes = {sum3[rgbbmp_pkg::ROWB_W-1:2], 2'b00};
    assign pad          = ~sum3[1:0];

    assign tile_bad = (col_first_reg != '0)
                   || (({1'b0, col_last_reg} + 11'd1) != {2'b00, image_width})
                   || ({1'b0, row_first_reg} != {1'b0, row_reg})
                   || (image_width == '0)
                   || ({{(rgbbmp_pkg::MAX_WIDTH_W-WW){1'b0}}, image_width}
                       > rgbbmp_pkg::MAX_WIDTH_W'(MAX_WIDTH))
                   || (col_reg != '0);

    assign pix_emit = open_reg && !fail_reg && tile_act_reg
                   && (row_reg <= tile_end_reg) && (row_reg < image_height);

    assign col_inc  = col_reg + 9'd1;
    assign row_done = col_inc >= image_width;

    always_comb
    begin
        case (op_reg)
            rgbbmp_pkg::OP_START: needs_job = 1'b1;
            rgbbmp_pkg::OP_PIXEL: needs_job = pix_emit;
            default:              needs_job = 1'b0;
        endcase
    end

    always_comb
    begin
        open_next     = open_reg;
        fail_next     = fail_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        tile_end_next = tile_end_reg;
        tile_act_next = tile_act_reg;
        case (op_reg)
            rgbbmp_pkg::OP_START:
            begin
                open_next     = 1'b1;
                fail_next     = 1'b0;
                row_next      = '0;
                col_next      = '0;
                tile_end_next = '0;
                tile_act_next = 1'b0;
            end
            rgbbmp_pkg::OP_TILE:
            begin
                if (open_reg && !fail_reg)
                begin
                    if (tile_bad)
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        tile_act_next = 1'b1;
                        tile_end_next = row_last_reg;
                    end
                end
            end
            rgbbmp_pkg::OP_PIXEL:
            begin
                if (pix_emit)
                begin
                    if (row_done)
                    begin
                        col_next = '0;
                        row_next = row_reg + 10'd1;
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
            end
            default:
            begin
                open_next = open_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= 1'b0;
            fail_reg     <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            tile_end_reg <= '0;
            tile_act_reg <= 1'b0;
        end
        else if (in_take)
        begin
            open_reg     <= open_next;
            fail_reg     <= fail_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            tile_end_reg <= tile_end_next;
            tile_act_reg <= tile_act_next;
        end
    end

    // widen each channel by repeating its top bits
    assign blue5  = pixel_reg[4:0];
    assign green6 = pixel_reg[10:5];
    assign red5   = pixel_reg[15:11];

    assign job_load = in_take && needs_job;

    always_comb
    begin
        job.is_hdr     = (op_reg == rgbbmp_pkg::OP_START);
        job.failed     = fail_next;
        job.hdr_width  = image_width;
        job.hdr_height = image_height;
        job.hdr_img    = rgbbmp_pkg::IMG_W'(stride_bytes) * rgbbmp_pkg::IMG_W'(image_height);
        job.pix_bgr    = {red5, red5[4:2], green6, green6[5:4], blue5, blue5[4:2]};
        if (op_reg == rgbbmp_pkg::OP_START)
        begin
            job.last_idx = rgbbmp_pkg::HDR_LAST_IDX;
        end
        else if (row_done)
        begin
            job.last_idx = 6'd2 + {4'b0000, pad};
        end
        else
        begin
            job.last_idx = 6'd2;
        end
    end

endmodule

// File: sv/rgbbmp_emit.sv
// byte sequencer for header and pixel runs with the output register
`timescale 1ns / 1ps

module rgbbmp_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_load,
    input  rgbbmp_pkg::job_t  job,
    output logic              job_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [0:0]        m_tuser
);

    rgbbmp_pkg::job_t              job_reg;
    logic                          job_valid_reg;
    logic [rgbbmp_pkg::IDX_W-1:0]  idx_reg;
    logic                          out_valid_reg;
    logic [7:0]                    out_byte_reg;
    logic                          out_last_reg;
    logic                          out_fail_reg;

    logic       advance;
    logic       at_last;
    logic [7:0] byte_now;

    assign advance   = job_valid_reg && (!out_valid_reg || m_tready);
    assign at_last   = (idx_reg == job_reg.last_idx);
    assign job_ready = !job_valid_reg || (advance && at_last);

    always_comb
    begin
        if (job_reg.is_hdr)
        begin
            byte_now = rgbbmp_pkg::header_byte(idx_reg, job_reg.hdr_width,
                                               job_reg.hdr_height, job_reg.hdr_img);
        end
        else
        begin
            case (idx_reg)
                6'd0:    byte_now = job_reg.pix_bgr[7:0];
                6'd1:    byte_now = job_reg.pix_bgr[15:8];
                6'd2:    byte_now = job_reg.pix_bgr[23:16];
                default: byte_now = 8'h00;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (job_load)
        begin
            job_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (advance)
        begin
            if (at_last)
            begin
                job_valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_now;
            out_last_reg <= at_last;
            out_fail_reg <= job_reg.failed;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_fail_reg;

endmodule

// File: sv/rgb565_to_bmp24_stream_core.sv
// top level of the rgb565 to top-down 24-bit bmp byte stream core
// usage:
//   input beats carry an operation in s_tuser: start (emits the 54-byte header),
//   tile announce (checks the band against width and current row, no output)
//   or pixel (emits blue, green, red and, at the end of a row, zero padding)
//   output beats carry one file byte each; m_tlast marks the last byte caused
//   by one input beat and m_tuser carries the sticky failure flag
//   image_width and image_height are written through cfg_we/cfg_addr/cfg_wdata
//   while the core is idle; the header uses the values present at the start beat
// timing:
//   the first output byte passes the input register, the job register and the output register
//   a pixel occupies the byte sequencer for three bytes, up to six at a row end,
//   a start beat for 54 bytes; a tile beat leaves the input register
//   without using the sequencer, which emits one byte per cycle while m_tready
//   allows it and sets the sustained rate
// reset and stall:
//   reset closes the image, clears the failure and loads width 480, height 320
//   when m_tready is low the output byte holds and the core stops taking beats
//   once its input register and sequencer are both occupied
`timescale 1ns / 1ps

module rgb565_to_bmp24_stream_core #(
    parameter int MAX_WIDTH = rgbbmp_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tile_first_column, tile_last_column, tile_first_row, tile_last_row, pixel_value
    input  logic [rgbbmp_pkg::S_DATA_W-1:0]   s_tdata,
    // operation
    input  logic [rgbbmp_pkg::OP_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_byte
    output logic [7:0]                        m_tdata,
    output logic                              m_tlast,
    // failed
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [rgbbmp_pkg::CFG_W-1:0]      cfg_wdata
);

    logic [rgbbmp_pkg::WIDTH_W-1:0]  width_reg;
    logic [rgbbmp_pkg::HEIGHT_W-1:0] height_reg;

    logic             job_load;
    logic             job_ready;
    rgbbmp_pkg::job_t job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rgbbmp_pkg::WIDTH_RST;
            height_reg <= rgbbmp_pkg::HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                rgbbmp_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[rgbbmp_pkg::WIDTH_W-1:0];
                rgbbmp_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[rgbbmp_pkg::HEIGHT_W-1:0];
                default:                width_reg  <= width_reg;
            endcase
        end
    end

    rgbbmp_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .image_width  (width_reg),
        .image_height (height_reg),
        .job_ready    (job_ready),
        .job_load     (job_load),
        .job          (job)
    );

    rgbbmp_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_load  (job_load),
        .job       (job),
        .job_ready (job_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
